// ===== rtl/kps_pkg.sv =====
// Shared constants, types and key table for the matrix keypad scanner.
package kps_pkg;

    localparam int MAX_COLUMNS    = 8;
    localparam int MAX_ROWS       = 8;
    localparam int KEY_TABLE_SIZE = 20;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int CNT_W  = 4;
    localparam int MASK_W = 16;
    localparam int CODE_W = 5;

    localparam logic [7:0]       SETTLE_RESET = 8'd20;
    localparam logic [CNT_W-1:0] COLS_RESET   = 4'd4;
    localparam logic [CNT_W-1:0] ROWS_RESET   = 4'd5;

    typedef enum logic [1:0] {
        CFG_SETTLE_TICKS = 2'd0,
        CFG_COLUMN_COUNT = 2'd1,
        CFG_ROW_COUNT    = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef logic [MASK_W-1:0] key_mask_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic [MASK_W-1:0] key_bits;
        logic              scan_done;
        logic [7:0]        column_drive;
    } result_t;

    localparam key_mask_t KEY_TABLE [KEY_TABLE_SIZE] = '{
        16'h0101, 16'h0102, 16'h0104, 16'h0108,
        16'h0201, 16'h0202, 16'h0204, 16'h0208,
        16'h0401, 16'h0402, 16'h0404, 16'h0408,
        16'h0801, 16'h0802, 16'h0804, 16'h0808,
        16'h1001, 16'h1002, 16'h1004, 16'h1008
    };

endpackage

// ===== rtl/kps_key_decode.sv =====
// Key table lookup: maps a finished scan mask to a key code, zero if unlisted.
module kps_key_decode
    import kps_pkg::*;
(
    input  key_mask_t         mask,
    output logic [CODE_W-1:0] key_code
);

    always_comb begin
        key_code = '0;
        for (int i = 0; i < KEY_TABLE_SIZE; i++) begin
            if (KEY_TABLE[i] == mask) begin
                key_code = CODE_W'(i + 1);
            end
        end
    end

endmodule

// ===== rtl/matrix_keypad_scanner_core.sv =====
// Top level of the matrix keypad scanner: column sequencing, row sampling, result register.
// Results: registered on accept, shown next cycle; one item per cycle unless m_tready
// stalls a held result, as the single result register is refilled while it drains.
// Reset: aresetn is synchronous, active low; it restores settle_ticks 20, column_count 4,
// row_count 5, and clears column, settle count, scan masks and the result valid.
module matrix_keypad_scanner_core
    import kps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] row_levels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] column_drive, [23:8] key_bits,
                                    // [28:24] key_code, [31:29] zero
    output logic        m_tlast,    // scan_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]       settle_ticks_reg;
    logic [CNT_W-1:0] column_count_reg;
    logic [CNT_W-1:0] row_count_reg;

    logic [COL_W-1:0] column_reg, column_next;
    logic [7:0]       settle_count_reg, settle_count_next;
    key_mask_t        scan_mask_reg, scan_mask_next;
    key_mask_t        previous_mask_reg, previous_mask_next;

    result_t          result_reg, result_next;
    logic             m_valid_reg;

    logic             accept;
    logic [CNT_W-1:0] cols_eff, rows_eff;
    logic [7:0]       row_enable;
    logic [7:0]       sampled;
    logic [7:0]       column_onehot;
    key_mask_t        mask_sampled;
    logic             last_column;
    logic             changed;
    logic [CODE_W-1:0] decoded_code;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'b000, result_reg.key_code, result_reg.key_bits,
                        result_reg.column_drive};
    assign m_tlast   = result_reg.scan_done;

    always_comb begin
        if (column_count_reg == '0) begin
            cols_eff = CNT_W'(1);
        end else if (column_count_reg > CNT_W'(MAX_COLUMNS)) begin
            cols_eff = CNT_W'(MAX_COLUMNS);
        end else begin
            cols_eff = column_count_reg;
        end
        if (row_count_reg > CNT_W'(MAX_ROWS)) begin
            rows_eff = CNT_W'(MAX_ROWS);
        end else begin
            rows_eff = row_count_reg;
        end
        for (int r = 0; r < 8; r++) begin
            row_enable[r] = (CNT_W'(r) < rows_eff);
        end
    end

    assign column_onehot = 8'(1) << column_reg;
    assign sampled       = s_tdata & row_enable;
    assign mask_sampled  = scan_mask_reg | ((|sampled) ? {sampled, column_onehot} : '0);
    assign last_column   = ({1'b0, column_reg} + CNT_W'(1)) >= cols_eff;
    assign changed       = mask_sampled != previous_mask_reg;

    kps_key_decode u_key_decode (
        .mask     (mask_sampled),
        .key_code (decoded_code)
    );

    always_comb begin
        column_next        = column_reg;
        settle_count_next  = settle_count_reg;
        scan_mask_next     = scan_mask_reg;
        previous_mask_next = previous_mask_reg;
        result_next              = '0;
        result_next.column_drive = column_onehot;
        if (settle_count_reg < settle_ticks_reg) begin
            settle_count_next = settle_count_reg + 8'd1;
        end else begin
            settle_count_next = '0;
            if (last_column) begin
                result_next.scan_done = 1'b1;
                if (changed) begin
                    previous_mask_next   = mask_sampled;
                    result_next.key_bits = mask_sampled;
                    result_next.key_code = decoded_code;
                end
                scan_mask_next = '0;
                column_next    = '0;
            end else begin
                scan_mask_next = mask_sampled;
                column_next    = column_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg <= SETTLE_RESET;
            column_count_reg <= COLS_RESET;
            row_count_reg    <= ROWS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SETTLE_TICKS: settle_ticks_reg <= cfg_data;
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data[CNT_W-1:0];
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg        <= '0;
            settle_count_reg  <= '0;
            scan_mask_reg     <= '0;
            previous_mask_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                column_reg        <= column_next;
                settle_count_reg  <= settle_count_next;
                scan_mask_reg     <= scan_mask_next;
                previous_mask_reg <= previous_mask_next;
                m_valid_reg       <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg       <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    a_drive_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[7:0]))
        else $error("column drive not one-hot");

    a_key_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[23:8] != '0 || m_tdata[28:24] != '0)) |-> m_tlast)
        else $error("key reported without finished scan");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[28:24] <= CODE_W'(KEY_TABLE_SIZE)))
        else $error("key code out of range");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

endmodule

// ===== tb/matrix_keypad_scanner_core_test.sv =====
// Self-checking testbench for the matrix keypad scanner core: stream stimulus, scoreboard.
`timescale 1ns / 1ps

import kps_pkg::*;

class keypad_scoreboard;
    logic [7:0]  settle_ticks;
    logic [3:0]  column_count;
    logic [3:0]  row_count;
    logic [2:0]  column;
    logic [7:0]  settle_count;
    key_mask_t   scan_mask;
    key_mask_t   last_mask;
    result_t     expected_q[$];
    int          errors;

    function new();
        settle_ticks = SETTLE_RESET;
        column_count = COLS_RESET;
        row_count    = ROWS_RESET;
        column       = '0;
        settle_count = '0;
        scan_mask    = '0;
        last_mask    = '0;
        errors       = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [7:0] data);
        case (idx)
            CFG_SETTLE_TICKS: begin
                settle_ticks = data;
            end
            CFG_COLUMN_COUNT: begin
                column_count = data[3:0];
            end
            CFG_ROW_COUNT: begin
                row_count = data[3:0];
            end
            default: begin
            end
        endcase
    endfunction

    function int current_column();
        return int'(column);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function logic [CODE_W-1:0] key_code_of(key_mask_t mask);
        for (int i = 0; i < KEY_TABLE_SIZE; i++) begin
            if (KEY_TABLE[i] == mask) begin
                return CODE_W'(i + 1);
            end
        end
        return '0;
    endfunction

    function void note_tick(logic [7:0] levels);
        int      cols;
        int      rows;
        result_t res;
        cols = (column_count == 0) ? 1 : ((column_count > MAX_COLUMNS) ? MAX_COLUMNS
                                                                       : int'(column_count));
        rows = (row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count);
        res = '0;
        res.column_drive = 8'(1) << column;
        if (settle_count < settle_ticks) begin
            settle_count = settle_count + 8'd1;
        end else begin
            for (int r = 0; r < rows; r++) begin
                if (levels[r]) begin
                    scan_mask = scan_mask | (key_mask_t'(1) << column)
                                          | (key_mask_t'(1) << (r + 8));
                end
            end
            settle_count = '0;
            if (int'(column) + 1 >= cols) begin
                res.scan_done = 1'b1;
                if (scan_mask != last_mask) begin
                    last_mask    = scan_mask;
                    res.key_bits = scan_mask;
                    res.key_code = key_code_of(scan_mask);
                end
                scan_mask = '0;
                column    = '0;
            end else begin
                column = column + 3'd1;
            end
        end
        expected_q.push_back(res);
    endfunction

    function void check_result(logic [31:0] data, logic last);
        result_t got;
        result_t exp;
        got.column_drive = data[7:0];
        got.scan_done    = last;
        got.key_bits     = data[23:8];
        got.key_code     = data[28:24];
        if (expected_q.size() == 0) begin
            if (errors < 10) begin
                $display("unexpected item: drive=%h done=%b bits=%h code=%0d",
                         got.column_drive, got.scan_done, got.key_bits, got.key_code);
            end
            errors++;
            return;
        end
        exp = expected_q.pop_front();
        if (got.column_drive !== exp.column_drive || got.scan_done !== exp.scan_done ||
            got.key_bits !== exp.key_bits || got.key_code !== exp.key_code ||
            data[31:29] !== 3'b000) begin
            if (errors < 10) begin
                $display("mismatch: drive exp %h got %h, done exp %b got %b, bits exp %h got %h, %s",
                         exp.column_drive, got.column_drive, exp.scan_done, got.scan_done,
                         exp.key_bits, got.key_bits,
                         $sformatf("code exp %0d got %0d, pad %b",
                                   exp.key_code, got.key_code, data[31:29]));
            end
            errors++;
        end
    endfunction
endclass

module matrix_keypad_scanner_core_test;

    localparam int IDLE_LIMIT = 2000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [7:0] row_levels
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [7:0] column_drive, [23:8] key_bits,
                                     // [28:24] key_code, [31:29] zero
    logic        m_tlast;            // scan_done
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    keypad_scoreboard board = new();
    int          burst_left = 8;
    int          cycle      = 0;
    logic [1:0]  stall_mode = '0;

    matrix_keypad_scanner_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle++;
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tlast);
        end
        if (cycle % 50 == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2'd2: begin
                m_tready <= (cycle % 5 == 0);
            end
            default: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
        endcase
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
                !aresetn) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("matrix_keypad_scanner_core_test NOT OK");
        $finish;
    end

    task automatic send_tick(input logic [7:0] levels);
        s_tvalid <= 1'b1;
        s_tdata  <= levels;
        do @(posedge aclk); while (!s_tready);
        board.note_tick(levels);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    function automatic logic [7:0] levels_for(input key_mask_t mask);
        return mask[board.current_column()] ? mask[15:8] : 8'h00;
    endfunction

    task automatic run_phase(input int n_items);
        key_mask_t  held;
        int         sel;
        logic [7:0] levels;
        held = '0;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    held = KEY_TABLE[$urandom_range(0, KEY_TABLE_SIZE - 1)];
                end else if (sel < 8) begin
                    held = KEY_TABLE[$urandom_range(0, KEY_TABLE_SIZE - 1)] |
                           KEY_TABLE[$urandom_range(0, KEY_TABLE_SIZE - 1)];
                end else if (sel == 8) begin
                    held = '0;
                end else begin
                    held = key_mask_t'($urandom);
                end
            end
            levels = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : levels_for(held);
            send_tick(levels);
        end
    endtask

    task automatic apply_settings(input logic [7:0] settle, input logic [3:0] cols,
                                  input logic [3:0] rows, input int n_items);
        drain();
        cfg_write(CFG_SETTLE_TICKS, settle);
        cfg_write(CFG_COLUMN_COUNT, {4'($urandom_range(0, 15)), cols});
        cfg_write(CFG_ROW_COUNT, {4'($urandom_range(0, 15)), rows});
        cfg_valid <= 1'b0;
        run_phase(n_items);
    endtask

    initial begin
        key_mask_t directed_masks [6];
        directed_masks = '{16'h0101, 16'h0101, 16'h0808, 16'h1008, 16'hFFFF, 16'h0000};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        cfg_write(CFG_UNUSED, 8'hA5);
        cfg_write(CFG_SETTLE_TICKS, 8'd0);
        cfg_valid <= 1'b0;
        foreach (directed_masks[k]) begin
            repeat (4) send_tick(levels_for(directed_masks[k]));
        end

        // column count lowered while the scan sits on a higher column
        apply_settings(8'd0, 4'd8, 4'd8, 61);
        apply_settings(8'd1, 4'd1, 4'd1, 60);
        apply_settings(8'd0, 4'd0, 4'd0, 40);
        apply_settings(8'd3, 4'd15, 4'd15, 70);
        apply_settings(8'd20, 4'd4, 4'd5, 60);
        apply_settings(8'd255, 4'd1, 4'd8, 260);
        apply_settings(8'd0, 4'd7, 4'd2, 50);
        repeat (3) begin
            apply_settings(8'($urandom_range(0, 4)), 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), 40);
        end

        drain();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("matrix_keypad_scanner_core_test OK");
        end else begin
            $display("matrix_keypad_scanner_core_test NOT OK");
        end
        $finish;
    end

endmodule
